>>> hdl/irq_bitmap_allocator_unit_macros.svh
// Assertion macros for the interrupt line allocator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef IRQ_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define IRQ_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define IBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IBA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IBA_ASSERT(lbl, clk, rst_n, prop, msg)
`define IBA_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

>>> hdl/ibau_pkg.sv
// Shared types, constants and helper functions of the interrupt line allocator.
// Has no dependencies; used by the interfaces and the allocator unit.
`default_nettype none

package ibau_pkg;

    localparam int MODE_W  = 3;
    localparam int LINE_W  = 8;
    localparam int MASK_W  = 64;
    localparam int WORD_W  = 64;
    localparam int WORD_AW = 6;

    localparam int RESET_LINE_A = 1;
    localparam int RESET_LINE_B = 12;

    localparam logic [LINE_W-1:0] NO_LINE      = 8'd255;
    localparam logic [LINE_W-1:0] ACTIVE_RESET = 8'd128;

    localparam logic [MODE_W-1:0] MODE_ALLOC_FIRST = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC_MASK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RESERVE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREE        = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY       = 3'd4;

    typedef struct packed {
        logic [LINE_W-1:0] line_out;
        logic              ok;
        logic              is_reserved;
    } t_result;

    localparam t_result RES_FAIL = '{line_out: NO_LINE, ok: 1'b0, is_reserved: 1'b0};

    function automatic logic [WORD_AW-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [WORD_AW-1:0] idx;
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (v[b]) begin
                idx = WORD_AW'(b);
            end
        end
        return idx;
    endfunction

    function automatic logic [WORD_W-1:0] reset_row(input logic first);
        logic [WORD_W-1:0] r;
        r = '0;
        if (first) begin
            r[RESET_LINE_A] = 1'b1;
            r[RESET_LINE_B] = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ibau_req_if.sv
// Request channel of the interrupt line allocator: valid, ready and one request word.
// Depends on ibau_pkg for field widths.
`default_nettype none

interface ibau_req_if;
    logic                          valid;
    logic                          ready;
    logic [ibau_pkg::MODE_W-1:0]   mode;
    logic [ibau_pkg::LINE_W-1:0]   line_index;
    logic [ibau_pkg::MASK_W-1:0]   candidate_mask;
    logic [ibau_pkg::LINE_W-1:0]   line_offset;

    modport source(output valid, output mode, output line_index, output candidate_mask,
                   output line_offset, input ready);
    modport sink(input valid, input mode, input line_index, input candidate_mask,
                 input line_offset, output ready);
endinterface

`default_nettype wire

>>> hdl/ibau_rsp_if.sv
// Response channel of the interrupt line allocator: valid, ready and one result word.
// Depends on ibau_pkg for field widths.
`default_nettype none

interface ibau_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ibau_pkg::LINE_W-1:0] line_out;
    logic                        ok;
    logic                        is_reserved;

    modport source(output valid, output line_out, output ok, output is_reserved,
                   input ready);
    modport sink(input valid, input line_out, input ok, input is_reserved, output ready);
endinterface

`default_nettype wire

>>> hdl/ibau_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module ibau_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 3
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/irq_bitmap_allocator_unit.sv
// A rejected request goes from acceptance straight to the publish state; reserve, free and
// query pass through read, check and publish; allocations repeat read and check per word.
// One request at a time; the next is taken the cycle after its result enters the output
// register, so a new request waits until the last one is through the word-by-word scan.
// Synchronous reset clears control state, sets the count to 128 and clears the row valid
// bits, so unwritten rows read as the reset pattern (lines 1 and 12 in use); no clearing pass.
`default_nettype none

`include "irq_bitmap_allocator_unit_macros.svh"

module irq_bitmap_allocator_unit #(
    parameter int MAX_LINES = 192,
    parameter int MASK_BITS = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ibau_pkg::LINE_W-1:0] i_cfg_wdata,
    ibau_req_if.sink                         i_req,
    ibau_rsp_if.source                       o_rsp
);

    localparam int NW   = (MAX_LINES + ibau_pkg::WORD_W - 1) / ibau_pkg::WORD_W;
    localparam int WI_W = (NW > 1) ? $clog2(NW) : 1;
    localparam int TOT  = NW * ibau_pkg::WORD_W;
    localparam int SH_W = TOT + ibau_pkg::MASK_W;

    localparam logic [ibau_pkg::LINE_W-1:0] MAX_L  = ibau_pkg::LINE_W'(MAX_LINES);
    localparam logic [WI_W-1:0]             LAST_W = WI_W'(NW - 1);
    localparam logic [ibau_pkg::MASK_W-1:0] MASK_KEEP =
        {ibau_pkg::MASK_W{1'b1}} >> (ibau_pkg::MASK_W - MASK_BITS);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CHECK, S_PUB} t_state;

    t_state                          r_state, n_state;
    logic [ibau_pkg::LINE_W-1:0]     r_active_count;
    logic [ibau_pkg::MODE_W-1:0]     r_mode;
    logic [ibau_pkg::LINE_W-1:0]     r_line;
    logic [WI_W-1:0]                 r_word, n_word;
    logic [TOT-1:0]                  r_allow, n_allow;
    logic [NW-1:0]                   r_row_valid;
    ibau_pkg::t_result               r_res, n_res;
    ibau_pkg::t_result               r_out;
    logic                            r_out_valid;

    logic [ibau_pkg::LINE_W-1:0]     count_eff;
    logic [TOT-1:0]                  below;
    logic [SH_W-1:0]                 shifted;
    logic                            accept;
    logic                            publish;
    logic                            ram_re;
    logic                            ram_we;
    logic [ibau_pkg::WORD_W-1:0]     ram_wdata;
    logic [ibau_pkg::WORD_W-1:0]     ram_q;
    logic [ibau_pkg::WORD_W-1:0]     q_eff;
    logic [ibau_pkg::WORD_W-1:0]     allow_word;
    logic [ibau_pkg::WORD_W-1:0]     cand;
    logic [ibau_pkg::WORD_W-1:0]     bitsel;
    logic [ibau_pkg::WORD_AW-1:0]    enc;

    ibau_ram #(
        .WIDTH(ibau_pkg::WORD_W),
        .DEPTH(NW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_word),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_word),
        .o_rdata(ram_q)
    );

    assign count_eff = (r_active_count < MAX_L) ? r_active_count : MAX_L;
    assign accept    = (r_state == S_IDLE) && i_req.valid;
    assign publish   = (r_state == S_PUB) && (!r_out_valid || o_rsp.ready);

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.line_out    = r_out.line_out;
    assign o_rsp.ok          = r_out.ok;
    assign o_rsp.is_reserved = r_out.is_reserved;

    always_comb begin
        for (int l = 0; l < TOT; l++) begin
            below[l] = (ibau_pkg::LINE_W'(l) < count_eff);
        end
        shifted = {TOT'(0), (i_req.candidate_mask & MASK_KEEP)} << i_req.line_offset;
        n_allow = ((i_req.mode == ibau_pkg::MODE_ALLOC_MASK) ? shifted[TOT-1:0] : '1) & below;
    end

    assign q_eff      = r_row_valid[r_word] ? ram_q : ibau_pkg::reset_row(r_word == '0);
    assign allow_word = r_allow[r_word * ibau_pkg::WORD_W +: ibau_pkg::WORD_W];
    assign cand       = ~q_eff & allow_word;
    assign enc        = ibau_pkg::lowest_set(cand);
    assign bitsel     = ibau_pkg::WORD_W'(1) << r_line[ibau_pkg::WORD_AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_word    = r_word;
        n_res     = r_res;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = q_eff;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.mode == ibau_pkg::MODE_ALLOC_FIRST ||
                        i_req.mode == ibau_pkg::MODE_ALLOC_MASK) begin
                        n_word  = '0;
                        n_state = S_READ;
                    end else if ((i_req.mode == ibau_pkg::MODE_RESERVE ||
                                  i_req.mode == ibau_pkg::MODE_FREE ||
                                  i_req.mode == ibau_pkg::MODE_QUERY) &&
                                 (i_req.line_index < count_eff)) begin
                        n_word  = WI_W'(i_req.line_index >> ibau_pkg::WORD_AW);
                        n_state = S_READ;
                    end else begin
                        n_res   = ibau_pkg::RES_FAIL;
                        n_state = S_PUB;
                    end
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_PUB;
                case (r_mode) inside
                    ibau_pkg::MODE_ALLOC_FIRST, ibau_pkg::MODE_ALLOC_MASK: begin
                        if (|cand) begin
                            ram_we    = 1'b1;
                            ram_wdata = q_eff | (ibau_pkg::WORD_W'(1) << enc);
                            n_res     = '{line_out: ibau_pkg::LINE_W'({r_word, enc}),
                                          ok: 1'b1, is_reserved: 1'b0};
                        end else if (r_word == LAST_W) begin
                            n_res = ibau_pkg::RES_FAIL;
                        end else begin
                            n_word  = r_word + 1'b1;
                            n_state = S_READ;
                        end
                    end
                    ibau_pkg::MODE_RESERVE: begin
                        ram_we    = 1'b1;
                        ram_wdata = q_eff | bitsel;
                        n_res     = '{line_out: r_line, ok: 1'b1, is_reserved: 1'b0};
                    end
                    ibau_pkg::MODE_FREE: begin
                        ram_we    = 1'b1;
                        ram_wdata = q_eff & ~bitsel;
                        n_res     = '{line_out: r_line, ok: 1'b1, is_reserved: 1'b0};
                    end
                    ibau_pkg::MODE_QUERY: begin
                        n_res = '{line_out: r_line, ok: 1'b1,
                                  is_reserved: q_eff[r_line[ibau_pkg::WORD_AW-1:0]]};
                    end
                    default: begin
                        n_res = ibau_pkg::RES_FAIL;
                    end
                endcase
            end
            S_PUB: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_word         <= '0;
            r_active_count <= ibau_pkg::ACTIVE_RESET;
            r_row_valid    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            if (i_cfg_we) begin
                r_active_count <= i_cfg_wdata;
            end
            if (ram_we) begin
                r_row_valid[r_word] <= 1'b1;
            end
            if (publish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_res <= n_res;
        if (accept) begin
            r_mode  <= i_req.mode;
            r_line  <= i_req.line_index;
            r_allow <= n_allow;
        end
        if (publish) begin
            r_out <= r_res;
        end
    end

    `IBA_ASSERT(a_fail_no_line, i_clk, i_rst_n,
        r_out_valid && !r_out.ok |-> r_out.line_out == ibau_pkg::NO_LINE,
        "A failed word must carry the invalid line.")
    `IBA_ASSERT(a_rsv_needs_ok, i_clk, i_rst_n,
        r_out_valid && r_out.is_reserved |-> r_out.ok,
        "A reserved answer must come with ok.")
    `IBA_ASSERT(a_ok_in_range, i_clk, i_rst_n,
        r_out_valid && r_out.ok |-> r_out.line_out < MAX_L,
        "A successful line must lie below the line limit.")
    `IBA_ASSERT(a_one_item, i_clk, i_rst_n,
        i_req.valid && i_req.ready |=> !i_req.ready,
        "A second request was taken while one was in work.")
    `IBA_ASSERT_NR(a_reset_clears, i_clk,
        !i_rst_n |=> !r_out_valid && r_state == S_IDLE,
        "Reset must leave the block idle with no word pending.")

endmodule

`default_nettype wire
